FILE: sv/swpd_pkg.sv
`timescale 1ns / 1ps
// swpd_pkg: shared constants for the single-wire pulse dimmer
// register indexes, reset values and fixed field widths; no dependencies

package swpd_pkg;

   localparam int LEVELS_DEFAULT = 16;

   localparam int PCT_MAX     = 100;
   localparam int ROUND_UP    = 99;
   localparam int HOLD_W      = 16;
   localparam int LEVEL_NOW_W = 5;
   localparam int PCT_W       = 8;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_OFF_HOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_HOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HALF = 2'd2;

   localparam logic [HOLD_W-1:0] OFF_HOLD_RESET   = 16'd3000;
   localparam logic [HOLD_W-1:0] WAKE_HOLD_RESET  = 16'd25;
   localparam logic [HOLD_W-1:0] PULSE_HALF_RESET = 16'd1;

endpackage

FILE: sv/single_wire_pulse_dimmer.sv
`timescale 1ns / 1ps
// single_wire_pulse_dimmer: percent request to pulse-count pin sequence
// depends on swpd_pkg for constants and register indexes
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   req      | req_valid/ready, req_percent       | in
//   rsp      | rsp_valid/ready, pin_level, hold_us| out
//            | level_now, last                    |
//   csr      | csr_valid/ready, index, data       | in
//
// one request is accepted in IDLE, divided by 100 in DIV by repeated use of the shared
// subtract/compare unit (quotient q = target level, at most LEVELS), planned in PLAN,
// then emitted one beat per cycle, up to 2*LEVELS-1 beats, when rsp_ready stays high
// rsp stalls hold the output register and freeze the sequencer
// reset: synchronous, level 0 (backlight off), registers at their defaults
// csr writes are always taken; landing them while the block is idle is up to the user, the block does not enforce it

module single_wire_pulse_dimmer
   import swpd_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [PCT_W-1:0]    req_percent,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pin_level,
   output logic [HOLD_W-1:0]          rsp_hold_us,
   output logic [LEVEL_NOW_W-1:0]     rsp_level_now,
   output logic                       rsp_last,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [HOLD_W-1:0]          csr_data
);

   // level width holds 0..LEVELS, numerator holds pct*LEVELS+99
   localparam int LW = $clog2(LEVELS + 1);
   localparam int NW = $clog2(PCT_MAX * LEVELS + PCT_MAX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PLAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [HOLD_W-1:0] off_hold_ff, off_hold_in;
   logic [HOLD_W-1:0] wake_hold_ff, wake_hold_in;
   logic [HOLD_W-1:0] pulse_half_ff, pulse_half_in;
   logic [LW-1:0]     cur_level_ff, cur_level_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [LW-1:0]     quot_ff, quot_in;
   logic              off_pend_ff, off_pend_in;
   logic              wake_pend_ff, wake_pend_in;
   logic              phase_ff, phase_in;
   logic [LW-1:0]     pulses_ff, pulses_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pin_ff, pin_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic [LEVEL_NOW_W-1:0] lvl_ff, lvl_in;
   logic                   last_ff, last_in;

   // request decode
   logic [PCT_W-2:0] pct;
   logic [NW-1:0]    numer;
   // plan
   logic [LW-1:0]    target;
   logic [LW-1:0]    cur_eff;
   logic [LW:0]      diff;
   // shared subtract/compare unit
   logic             rem_ge;
   logic [NW-1:0]    rem_sub;
   logic             slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = pin_ff;
   assign rsp_hold_us   = hold_ff;
   assign rsp_level_now = lvl_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      // clamp: negative to 0, above 100 to 100
      if (req_percent[PCT_W-1]) begin
         pct = '0;
      end else if (req_percent > PCT_W'(PCT_MAX)) begin
         pct = (PCT_W-1)'(PCT_MAX);
      end else begin
         pct = req_percent[PCT_W-2:0];
      end
      if (pct == '0) begin
         numer = '0;
      end else begin
         numer = NW'(pct) * NW'(LEVELS) + NW'(ROUND_UP);
      end
   end

   // one compare and subtract by 100 per cycle
   assign rem_ge  = (rem_ff >= NW'(PCT_MAX));
   assign rem_sub = rem_ff - NW'(PCT_MAX);

   always_comb begin
      target  = (quot_ff > LW'(LEVELS)) ? LW'(LEVELS) : quot_ff;
      // off driver wakes at full level
      cur_eff = (cur_level_ff == '0) ? LW'(LEVELS) : cur_level_ff;
      // step-down count modulo LEVELS
      if (cur_eff < target) begin
         diff = {1'b0, cur_eff} + (LW+1)'(LEVELS) - {1'b0, target};
      end else begin
         diff = {1'b0, cur_eff} - {1'b0, target};
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      off_hold_in   = off_hold_ff;
      wake_hold_in  = wake_hold_ff;
      pulse_half_in = pulse_half_ff;
      cur_level_in  = cur_level_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      off_pend_in   = off_pend_ff;
      wake_pend_in  = wake_pend_ff;
      phase_in      = phase_ff;
      pulses_in     = pulses_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pin_in        = pin_ff;
      hold_in       = hold_ff;
      lvl_in        = lvl_ff;
      last_in       = last_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_OFF_HOLD:   off_hold_in   = csr_data;
            CSR_WAKE_HOLD:  wake_hold_in  = csr_data;
            CSR_PULSE_HALF: pulse_half_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in   = numer;
               quot_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ge) begin
               rem_in  = rem_sub;
               quot_in = quot_ff + LW'(1);
            end else begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (target == cur_level_ff) begin
               state_in = ST_IDLE;
            end else begin
               cur_level_in = target;
               off_pend_in  = (target == '0);
               wake_pend_in = (cur_level_ff == '0);
               phase_in     = 1'b0;
               pulses_in    = diff[LW-1:0];
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               // new level is already in cur_level_ff for every beat
               lvl_in       = LEVEL_NOW_W'(cur_level_ff);
               if (off_pend_ff) begin
                  pin_in      = 1'b0;
                  hold_in     = off_hold_ff;
                  last_in     = 1'b1;
                  off_pend_in = 1'b0;
                  state_in    = ST_IDLE;
               end else if (wake_pend_ff) begin
                  pin_in       = 1'b1;
                  hold_in      = wake_hold_ff;
                  last_in      = (pulses_ff == '0);
                  wake_pend_in = 1'b0;
                  if (pulses_ff == '0) begin
                     state_in = ST_IDLE;
                  end
               end else if (!phase_ff) begin
                  // low half of a dimming pulse
                  pin_in   = 1'b0;
                  hold_in  = pulse_half_ff;
                  last_in  = 1'b0;
                  phase_in = 1'b1;
               end else begin
                  // high half closes the pulse
                  pin_in    = 1'b1;
                  hold_in   = pulse_half_ff;
                  last_in   = (pulses_ff == LW'(1));
                  phase_in  = 1'b0;
                  pulses_in = pulses_ff - LW'(1);
                  if (pulses_ff == LW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         off_hold_ff   <= OFF_HOLD_RESET;
         wake_hold_ff  <= WAKE_HOLD_RESET;
         pulse_half_ff <= PULSE_HALF_RESET;
         cur_level_ff  <= '0;
         off_pend_ff   <= 1'b0;
         wake_pend_ff  <= 1'b0;
         phase_ff      <= 1'b0;
         pulses_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         off_hold_ff   <= off_hold_in;
         wake_hold_ff  <= wake_hold_in;
         pulse_half_ff <= pulse_half_in;
         cur_level_ff  <= cur_level_in;
         off_pend_ff   <= off_pend_in;
         wake_pend_ff  <= wake_pend_in;
         phase_ff      <= phase_in;
         pulses_ff     <= pulses_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      pin_ff  <= pin_in;
      hold_ff <= hold_in;
      lvl_ff  <= lvl_in;
      last_ff <= last_in;
   end

endmodule
